[sv/assert_macros.svh]
// Assertion helpers shared by the breaker control RTL.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define BMS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("breaker control assertion failed");

// A property whose consequent is checked in the cycle after its antecedent.
`define BMS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("breaker control sequence assertion failed");

`endif

[sv/bms_pkg.sv]
`timescale 1ns / 1ps

package bms_pkg;

	typedef enum logic [2:0] {
		ST_OPENED      = 3'd0,
		ST_SUPPLY_WAIT = 3'd1,
		ST_CLOSE_WAIT  = 3'd2,
		ST_CLOSED      = 3'd3,
		ST_OPEN_WAIT   = 3'd4
	} bms_state_t;

	typedef enum logic [2:0] {
		CA_NONE  = 3'd0,
		CA_EXT   = 3'd1,
		CA_OCP   = 3'd2,
		CA_OCD   = 3'd3,
		CA_OTHER = 3'd4
	} cause_t;

	typedef enum logic [1:0] {
		TM_NONE    = 2'd0,
		TM_START   = 2'd1,
		TM_CANCEL  = 2'd2,
		TM_RESTART = 2'd3
	} timer_ctl_t;

	typedef enum logic [1:0] {
		MOD_NONE    = 2'd0,
		MOD_CLEANUP = 2'd1,
		MOD_FORWARD = 2'd2
	} mod_action_t;

	typedef enum logic [3:0] {
		EV_CLOSE        = 4'd0,
		EV_OPEN         = 4'd1,
		EV_ZERO_CROSS   = 4'd2,
		EV_SUPPLY_TMR   = 4'd3,
		EV_RECOVERY_TMR = 4'd4,
		EV_SW_CLOSED    = 4'd5,
		EV_SW_OPENED    = 4'd6,
		EV_OCD          = 4'd7,
		EV_RESET_TMR    = 4'd8
	} event_t;

	localparam logic [3:0] EV_LAST = EV_RESET_TMR;

	// Open cause reported by the switch itself.
	localparam logic [1:0] SC_OTHER = 2'd0;
	localparam logic [1:0] SC_OCP   = 2'd1;
	localparam logic [1:0] SC_EXT   = 2'd2;

	typedef enum logic [1:0] {
		REG_RECOVERY = 2'd0,
		REG_MODE     = 2'd1,
		REG_AC_MIN   = 2'd2
	} reg_idx_t;

	localparam logic [7:0] AC_MIN_RESET = 8'd2;
	localparam logic [7:0] COUNT_MAX    = 8'hFF;

	typedef struct packed {
		logic [7:0] recovery_attempts;
		logic       close_mode;
		logic [7:0] ac_crossing_min;
	} bms_cfg_t;

	typedef struct packed {
		bms_state_t  breaker_state;
		cause_t      trip_cause;
		logic        supply_is_ac;
		logic        switch_on_request;
		logic        switch_off_request;
		timer_ctl_t  supply_timer_ctl;
		timer_ctl_t  recovery_timer_ctl;
		timer_ctl_t  reset_timer_ctl;
		logic        notify_pulse;
		logic [7:0]  attempts_left;
		mod_action_t modulator_action;
	} bms_result_t;

	// The switch's own cause overrides the trip cause, except for an external open.
	function automatic cause_t cause_from_switch(cause_t cur, logic [1:0] sc);
		cause_t res;
		res = cur;
		if (sc == SC_OCP) begin
			res = CA_OCP;
		end else if (sc != SC_EXT) begin
			res = CA_OTHER;
		end
		return res;
	endfunction

endpackage

[sv/bms_regs.sv]
`timescale 1ns / 1ps

module bms_regs import bms_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output bms_cfg_t    cfg
);

	bms_cfg_t cfg_q;
	logic     wr_en;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.recovery_attempts <= '0;
			cfg_q.close_mode        <= 1'b0;
			cfg_q.ac_crossing_min   <= AC_MIN_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_RECOVERY: cfg_q.recovery_attempts <= pwdata[7:0];
				REG_MODE:     cfg_q.close_mode        <= pwdata[0];
				REG_AC_MIN:   cfg_q.ac_crossing_min   <= pwdata[7:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_RECOVERY: prdata = {24'd0, cfg_q.recovery_attempts};
			REG_MODE:     prdata = {31'd0, cfg_q.close_mode};
			REG_AC_MIN:   prdata = {24'd0, cfg_q.ac_crossing_min};
			default:      prdata = '0;
		endcase
	end

endmodule

[sv/bms_fsm.sv]
`timescale 1ns / 1ps

module bms_fsm import bms_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [3:0]  cmd,
	input  logic        switch_is_on,
	input  logic        switch_close_fails,
	input  logic [1:0]  switch_cause,
	input  bms_cfg_t    cfg,
	output bms_result_t res_d
);

	bms_state_t  state_q, state_d;
	cause_t      cause_q, cause_d;
	logic [7:0]  cnt_q, cnt_d;
	logic        ac_q, ac_d;
	logic        mask_q, mask_d;
	logic [7:0]  rem_q, rem_d;
	logic        amode_q, amode_d;

	logic        ev_ok;
	logic        stay_closed;
	logic        mode_change;
	logic        dc_start;

	logic        on_req, off_req, notify;
	timer_ctl_t  sup_tm, rec_tm, rst_tm;
	mod_action_t mod_act;

	// A masked zero crossing and an unknown code leave everything untouched.
	assign ev_ok = (cmd <= EV_LAST) && !((cmd == EV_ZERO_CROSS) && mask_q);

	// Events in the closed state after which the mode check still applies.
	assign stay_closed = ev_ok && (state_q == ST_CLOSED) && (cmd != EV_OPEN) &&
		(cmd != EV_OCD) && !((cmd == EV_SW_OPENED) && (switch_cause != SC_EXT));
	assign mode_change = stay_closed && (amode_q != cfg.close_mode);
	assign dc_start    = cnt_q < cfg.ac_crossing_min;

	// Next state and the stored status.
	always_comb begin
		state_d = state_q;
		cause_d = cause_q;
		cnt_d   = cnt_q;
		ac_d    = ac_q;
		mask_d  = mask_q;
		rem_d   = rem_q;
		amode_d = amode_q;
		if (ev_ok) begin
			case (state_q)
				ST_OPENED: begin
					if (cmd == EV_CLOSE) begin
						cnt_d   = '0;
						state_d = ST_SUPPLY_WAIT;
						cause_d = CA_EXT;
						amode_d = 1'b0;
						rem_d   = cfg.recovery_attempts;
						mask_d  = 1'b0;
					end
				end
				ST_SUPPLY_WAIT: begin
					if (cmd == EV_OPEN) begin
						mask_d  = 1'b1;
						state_d = ST_OPENED;
						cause_d = CA_EXT;
					end else if (cmd == EV_ZERO_CROSS) begin
						if (cnt_q != COUNT_MAX) begin
							cnt_d = cnt_q + 8'd1;
						end
					end else if (cmd == EV_SUPPLY_TMR) begin
						cnt_d   = '0;
						state_d = ST_CLOSE_WAIT;
						if (dc_start) begin
							ac_d   = 1'b0;
							mask_d = 1'b1;
							if (switch_close_fails) begin
								cause_d = cause_from_switch(cause_q, switch_cause);
							end
						end else begin
							ac_d = 1'b1;
						end
					end
				end
				ST_CLOSE_WAIT: begin
					if (cmd == EV_OPEN) begin
						cause_d = CA_EXT;
						if (!switch_is_on) begin
							state_d = ST_OPENED;
							mask_d  = 1'b1;
						end else begin
							state_d = ST_OPEN_WAIT;
						end
					end else if ((cmd == EV_ZERO_CROSS) || (cmd == EV_RECOVERY_TMR)) begin
						if (switch_close_fails) begin
							cause_d = cause_from_switch(cause_q, switch_cause);
						end
					end else if (cmd == EV_SW_CLOSED) begin
						state_d = ST_CLOSED;
					end
				end
				ST_CLOSED: begin
					if (cmd == EV_OPEN) begin
						cause_d = CA_EXT;
						if (!switch_is_on) begin
							state_d = ST_OPENED;
							mask_d  = 1'b1;
						end else begin
							state_d = ST_OPEN_WAIT;
						end
					end else if (cmd == EV_OCD) begin
						state_d = ST_OPEN_WAIT;
						cause_d = CA_OCD;
					end else if (cmd == EV_SW_OPENED) begin
						if (switch_cause != SC_EXT) begin
							if ((switch_cause != SC_OCP) || (rem_q == 8'd0)) begin
								mask_d  = 1'b1;
								state_d = ST_OPENED;
								cause_d = cause_from_switch(cause_q, switch_cause);
							end else begin
								rem_d   = rem_q - 8'd1;
								state_d = ST_CLOSE_WAIT;
							end
						end
					end else if (cmd == EV_RESET_TMR) begin
						rem_d = cfg.recovery_attempts;
					end
					if (mode_change) begin
						amode_d = cfg.close_mode;
						if (!switch_is_on) begin
							state_d = ST_CLOSE_WAIT;
							if (!ac_q && switch_close_fails) begin
								cause_d = cause_from_switch(cause_q, switch_cause);
							end
						end
					end
				end
				ST_OPEN_WAIT: begin
					if (cmd == EV_SW_OPENED) begin
						state_d = ST_OPENED;
						mask_d  = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Pulses and timer commands that go with the event.
	always_comb begin
		on_req  = 1'b0;
		off_req = 1'b0;
		notify  = 1'b0;
		sup_tm  = TM_NONE;
		rec_tm  = TM_NONE;
		rst_tm  = TM_NONE;
		mod_act = MOD_NONE;
		if (ev_ok) begin
			case (state_q)
				ST_OPENED: begin
					if (cmd == EV_CLOSE) begin
						sup_tm = TM_RESTART;
					end
				end
				ST_SUPPLY_WAIT: begin
					if (cmd == EV_OPEN) begin
						sup_tm = TM_CANCEL;
					end else if ((cmd == EV_SUPPLY_TMR) && dc_start) begin
						on_req = 1'b1;
					end
				end
				ST_CLOSE_WAIT: begin
					if (cmd == EV_OPEN) begin
						off_req = switch_is_on && !ac_q;
					end else if ((cmd == EV_ZERO_CROSS) || (cmd == EV_RECOVERY_TMR)) begin
						rec_tm = TM_CANCEL;
						on_req = 1'b1;
					end else if (cmd == EV_SW_CLOSED) begin
						if (rem_q < cfg.recovery_attempts) begin
							rst_tm = TM_START;
						end
					end
				end
				ST_CLOSED: begin
					if (cmd == EV_OPEN) begin
						off_req = switch_is_on && !ac_q;
					end else if (cmd == EV_OCD) begin
						off_req = !ac_q;
					end else if (cmd == EV_SW_OPENED) begin
						rst_tm = TM_CANCEL;
						if (switch_cause != SC_EXT) begin
							if ((switch_cause != SC_OCP) || (rem_q == 8'd0)) begin
								notify = 1'b1;
							end else if (!ac_q) begin
								rec_tm = TM_START;
							end
						end
					end
					if (mode_change) begin
						mod_act = cfg.close_mode ? MOD_CLEANUP : MOD_NONE;
						on_req  = !switch_is_on && !ac_q;
					end else if (stay_closed && amode_q && ac_q) begin
						mod_act = MOD_FORWARD;
					end
				end
				ST_OPEN_WAIT: begin
					if (cmd == EV_ZERO_CROSS) begin
						off_req = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_OPENED;
			cause_q <= CA_NONE;
			cnt_q   <= '0;
			ac_q    <= 1'b0;
			mask_q  <= 1'b0;
			rem_q   <= '0;
			amode_q <= 1'b0;
		end else if (accept) begin
			state_q <= state_d;
			cause_q <= cause_d;
			cnt_q   <= cnt_d;
			ac_q    <= ac_d;
			mask_q  <= mask_d;
			rem_q   <= rem_d;
			amode_q <= amode_d;
		end
	end

	always_comb begin
		res_d.breaker_state      = state_d;
		res_d.trip_cause         = cause_d;
		res_d.supply_is_ac       = ac_d;
		res_d.switch_on_request  = on_req;
		res_d.switch_off_request = off_req;
		res_d.supply_timer_ctl   = sup_tm;
		res_d.recovery_timer_ctl = rec_tm;
		res_d.reset_timer_ctl    = rst_tm;
		res_d.notify_pulse       = notify;
		res_d.attempts_left      = rem_d;
		res_d.modulator_action   = mod_act;
	end

endmodule

[sv/bms_out.sv]
`timescale 1ns / 1ps

module bms_out import bms_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  bms_result_t res_d,
	input  logic        res_ready,
	output logic        res_valid,
	output logic        take,
	output bms_result_t res
);

	logic        valid_q;
	bms_result_t res_q;

	// A new beat may enter when no beat is held or the held one leaves in the same cycle.
	assign take      = !valid_q || res_ready;
	assign res_valid = valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_d;
		end
	end

endmodule

[sv/breaker_main_state_machine.sv]
// Channel   Handshake                Beat contents
// cmd       cmd_valid / cmd_ready    cmd, switch_is_on, switch_close_fails, switch_cause
// res       res_valid / res_ready    state, cause, AC flag, requests, timer controls, notify,
//                                    attempts left, modulator action
// config    APB psel/penable/pwrite  recovery_attempts 0x0, close_mode 0x4, ac_crossing_min 0x8
//
// Each beat is decoded against the state registers in one combinational pass, and its result
// lands in the output register on the edge that accepts it.
// A beat is accepted every cycle as long as the output register is empty or being drained.
// Reset puts the breaker in the opened state with no cause, counters and flags cleared.
// A stall on the result side holds the output register and backs up into cmd_ready only.
`timescale 1ns / 1ps

module breaker_main_state_machine import bms_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  logic [3:0]  cmd,
	input  logic        switch_is_on,
	input  logic        switch_close_fails,
	input  logic [1:0]  switch_cause,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [2:0]  breaker_state,
	output logic [2:0]  trip_cause,
	output logic        supply_is_ac,
	output logic        switch_on_request,
	output logic        switch_off_request,
	output logic [1:0]  supply_timer_ctl,
	output logic [1:0]  recovery_timer_ctl,
	output logic [1:0]  reset_timer_ctl,
	output logic        notify_pulse,
	output logic [7:0]  attempts_left,
	output logic [1:0]  modulator_action
);

`include "assert_macros.svh"

	bms_cfg_t    cfg;
	bms_result_t res_d;
	bms_result_t res;
	logic        accept;

	assign accept = cmd_valid && cmd_ready;

	bms_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bms_fsm u_fsm (
		.clk                (clk),
		.arst_n             (arst_n),
		.accept             (accept),
		.cmd                (cmd),
		.switch_is_on       (switch_is_on),
		.switch_close_fails (switch_close_fails),
		.switch_cause       (switch_cause),
		.cfg                (cfg),
		.res_d              (res_d)
	);

	bms_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.res_d     (res_d),
		.res_ready (res_ready),
		.res_valid (res_valid),
		.take      (cmd_ready),
		.res       (res)
	);

	assign breaker_state      = res.breaker_state;
	assign trip_cause         = res.trip_cause;
	assign supply_is_ac       = res.supply_is_ac;
	assign switch_on_request  = res.switch_on_request;
	assign switch_off_request = res.switch_off_request;
	assign supply_timer_ctl   = res.supply_timer_ctl;
	assign recovery_timer_ctl = res.recovery_timer_ctl;
	assign reset_timer_ctl    = res.reset_timer_ctl;
	assign notify_pulse       = res.notify_pulse;
	assign attempts_left      = res.attempts_left;
	assign modulator_action   = res.modulator_action;

	`BMS_ASSERT(a_on_off_excl, res_valid |-> !(switch_on_request && switch_off_request))
	`BMS_ASSERT(a_notify_opened, (res_valid && notify_pulse) |-> (breaker_state == ST_OPENED))
	`BMS_ASSERT(a_fwd_closed, (res_valid && (modulator_action == MOD_FORWARD)) |-> (breaker_state == ST_CLOSED))
	`BMS_ASSERT_NEXT(a_accept_shows, accept, res_valid)

endmodule

[dv/tb_breaker_main_state_machine.sv]
`timescale 1ns / 1ps

module tb_breaker_main_state_machine;
	import bms_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD   = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        cmd_valid = 1'b0;
	logic        cmd_ready;
	logic [3:0]  cmd = '0;
	logic        switch_is_on = 1'b0;
	logic        switch_close_fails = 1'b0;
	logic [1:0]  switch_cause = '0;
	logic        res_valid;
	logic        res_ready = 1'b0;
	logic [2:0]  breaker_state;
	logic [2:0]  trip_cause;
	logic        supply_is_ac;
	logic        switch_on_request;
	logic        switch_off_request;
	logic [1:0]  supply_timer_ctl;
	logic [1:0]  recovery_timer_ctl;
	logic [1:0]  reset_timer_ctl;
	logic        notify_pulse;
	logic [7:0]  attempts_left;
	logic [1:0]  modulator_action;

	breaker_main_state_machine DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.switch_is_on(switch_is_on),
		.switch_close_fails(switch_close_fails),
		.switch_cause(switch_cause),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.breaker_state(breaker_state),
		.trip_cause(trip_cause),
		.supply_is_ac(supply_is_ac),
		.switch_on_request(switch_on_request),
		.switch_off_request(switch_off_request),
		.supply_timer_ctl(supply_timer_ctl),
		.recovery_timer_ctl(recovery_timer_ctl),
		.reset_timer_ctl(reset_timer_ctl),
		.notify_pulse(notify_pulse),
		.attempts_left(attempts_left),
		.modulator_action(modulator_action)
	);

	always #2 clk = ~clk;

	// Shadow copy of the breaker registers and state.
	bms_cfg_t   cfg;
	bms_state_t mdl_state;
	cause_t     mdl_cause;
	logic [7:0] mdl_count;
	logic       mdl_ac;
	logic       mdl_masked;
	logic [7:0] mdl_attempts;
	logic       mdl_mode;

	bms_result_t pending_breaker_results[$];
	bms_result_t exp_r;

	int error_count = 0;
	int events_sent = 0;
	int results_seen = 0;
	int config_writes = 0;
	int cycle_count = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int rx_stall_left = 0;
	logic start_hold = 1'b0;

	function cause_t refused_close_cause(cause_t cur, logic [1:0] sc);
		if (sc == SC_OCP) begin
			return CA_OCP;
		end
		if (sc == SC_EXT) begin
			return cur;
		end
		return CA_OTHER;
	endfunction

	function void request_close(logic fails, logic [1:0] sc, inout bms_result_t r);
		r.switch_on_request = 1'b1;
		if (fails) begin
			mdl_cause = refused_close_cause(mdl_cause, sc);
		end
	endfunction

	function void open_by_command(logic sw_on, inout bms_result_t r);
		mdl_cause = CA_EXT;
		if (!sw_on) begin
			mdl_state = ST_OPENED;
			mdl_masked = 1'b1;
		end else begin
			mdl_state = ST_OPEN_WAIT;
			if (!mdl_ac) begin
				r.switch_off_request = 1'b1;
			end
		end
	endfunction

	// Advances the shadow state by one event and returns the result it produces.
	function bms_result_t breaker_step(logic [3:0] ev, logic sw_on, logic fails,
			logic [1:0] sc);
		bms_result_t r;
		logic [7:0] cnt;
		r = '0;
		if (ev <= EV_LAST && !(ev == EV_ZERO_CROSS && mdl_masked)) begin
			case (mdl_state)
				ST_OPENED: begin
					if (ev == EV_CLOSE) begin
						r.supply_timer_ctl = TM_RESTART;
						mdl_count = '0;
						mdl_state = ST_SUPPLY_WAIT;
						mdl_cause = CA_EXT;
						mdl_mode = 1'b0;
						mdl_attempts = cfg.recovery_attempts;
						mdl_masked = 1'b0;
					end
				end
				ST_SUPPLY_WAIT: begin
					if (ev == EV_OPEN) begin
						r.supply_timer_ctl = TM_CANCEL;
						mdl_masked = 1'b1;
						mdl_state = ST_OPENED;
						mdl_cause = CA_EXT;
					end else if (ev == EV_ZERO_CROSS) begin
						if (mdl_count != COUNT_MAX) begin
							mdl_count = mdl_count + 8'd1;
						end
					end else if (ev == EV_SUPPLY_TMR) begin
						cnt = mdl_count;
						mdl_count = '0;
						mdl_state = ST_CLOSE_WAIT;
						if (cnt < cfg.ac_crossing_min) begin
							mdl_ac = 1'b0;
							mdl_masked = 1'b1;
							request_close(fails, sc, r);
						end else begin
							mdl_ac = 1'b1;
						end
					end
				end
				ST_CLOSE_WAIT: begin
					if (ev == EV_OPEN) begin
						open_by_command(sw_on, r);
					end else if (ev == EV_ZERO_CROSS || ev == EV_RECOVERY_TMR) begin
						r.recovery_timer_ctl = TM_CANCEL;
						request_close(fails, sc, r);
					end else if (ev == EV_SW_CLOSED) begin
						mdl_state = ST_CLOSED;
						if (mdl_attempts < cfg.recovery_attempts) begin
							r.reset_timer_ctl = TM_START;
						end
					end
				end
				ST_CLOSED: begin
					if (ev == EV_OPEN) begin
						open_by_command(sw_on, r);
					end else if (ev == EV_OCD) begin
						mdl_state = ST_OPEN_WAIT;
						mdl_cause = CA_OCD;
						if (!mdl_ac) begin
							r.switch_off_request = 1'b1;
						end
					end else if (ev == EV_SW_OPENED) begin
						r.reset_timer_ctl = TM_CANCEL;
						// An external cause means the modulator opened the switch itself.
						if (sc != SC_EXT) begin
							if (sc != SC_OCP || mdl_attempts == 8'd0) begin
								mdl_masked = 1'b1;
								mdl_state = ST_OPENED;
								mdl_cause = refused_close_cause(mdl_cause, sc);
								r.notify_pulse = 1'b1;
							end else begin
								mdl_attempts = mdl_attempts - 8'd1;
								mdl_state = ST_CLOSE_WAIT;
								if (!mdl_ac) begin
									r.recovery_timer_ctl = TM_START;
								end
							end
						end
					end else if (ev == EV_RESET_TMR) begin
						mdl_attempts = cfg.recovery_attempts;
					end
					// Every event that leaves the breaker closed also passes the mode check.
					if (mdl_state == ST_CLOSED) begin
						if (mdl_mode != cfg.close_mode) begin
							mdl_mode = cfg.close_mode;
							if (mdl_mode) begin
								r.modulator_action = MOD_CLEANUP;
							end
							if (!sw_on) begin
								mdl_state = ST_CLOSE_WAIT;
								if (!mdl_ac) begin
									request_close(fails, sc, r);
								end
							end
						end else if (mdl_mode && mdl_ac) begin
							r.modulator_action = MOD_FORWARD;
						end
					end
				end
				ST_OPEN_WAIT: begin
					if (ev == EV_ZERO_CROSS) begin
						r.switch_off_request = 1'b1;
					end else if (ev == EV_SW_OPENED) begin
						mdl_state = ST_OPENED;
						mdl_masked = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
		r.breaker_state = mdl_state;
		r.trip_cause = mdl_cause;
		r.supply_is_ac = mdl_ac;
		r.attempts_left = mdl_attempts;
		return r;
	endfunction

	task send_event(logic [3:0] ev, logic sw_on, logic fails, logic [1:0] sc);
		if (tx_idle_pct != 0 && $urandom_range(1, 100) <= tx_idle_pct) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= ev;
		switch_is_on <= sw_on;
		switch_close_fails <= fails;
		switch_cause <= sc;
		do @(posedge clk); while (!cmd_ready);
		pending_breaker_results.push_back(breaker_step(ev, sw_on, fails, sc));
		events_sent++;
	endtask

	// Mostly events that make sense in the current state, with some noise.
	task pick_event(output logic [3:0] ev, output logic sw_on, output logic fails,
			output logic [1:0] sc);
		int roll;
		roll = $urandom_range(0, 99);
		sw_on = 1'($urandom_range(0, 1));
		fails = ($urandom_range(0, 3) == 0);
		sc = 2'($urandom_range(0, 3));
		if ($urandom_range(0, 99) < 12) begin
			ev = 4'($urandom_range(0, 15));
		end else begin
			case (mdl_state)
				ST_OPENED: begin
					ev = (roll < 85) ? EV_CLOSE : 4'($urandom_range(0, 8));
				end
				ST_SUPPLY_WAIT: begin
					if (roll < 65) ev = EV_ZERO_CROSS;
					else if (roll < 94) ev = EV_SUPPLY_TMR;
					else ev = EV_OPEN;
				end
				ST_CLOSE_WAIT: begin
					if (roll < 55) ev = EV_SW_CLOSED;
					else if (roll < 75) ev = EV_RECOVERY_TMR;
					else if (roll < 88) ev = EV_ZERO_CROSS;
					else ev = EV_OPEN;
				end
				ST_CLOSED: begin
					sw_on = ($urandom_range(0, 5) != 0);
					if (roll < 20) ev = EV_RESET_TMR;
					else if (roll < 35) ev = EV_OCD;
					else if (roll < 65) ev = EV_SW_OPENED;
					else if (roll < 75) ev = EV_OPEN;
					else ev = 4'($urandom_range(0, 8));
				end
				default: begin
					ev = (roll < 40) ? EV_ZERO_CROSS : EV_SW_OPENED;
				end
			endcase
		end
	endtask

	// Register writes only happen with no beat in flight.
	task set_config(reg_idx_t idx, logic [31:0] value);
		cmd_valid <= 1'b0;
		while (pending_breaker_results.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_RECOVERY: cfg.recovery_attempts = value[7:0];
			REG_MODE:     cfg.close_mode = value[0];
			REG_AC_MIN:   cfg.ac_crossing_min = value[7:0];
			default: begin
			end
		endcase
		config_writes++;
	endtask

	task check_field(string name, int unsigned expected, int unsigned actual);
		if (expected != actual) begin
			$error("%s mismatch: expected %0d, actual %0d", name, expected, actual);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			results_seen++;
			if (pending_breaker_results.size() == 0) begin
				$error("result beat arrived with no expected result waiting");
				error_count++;
			end else begin
				exp_r = pending_breaker_results.pop_front();
				check_field("breaker_state", exp_r.breaker_state, breaker_state);
				check_field("trip_cause", exp_r.trip_cause, trip_cause);
				check_field("supply_is_ac", exp_r.supply_is_ac, supply_is_ac);
				check_field("switch_on_request", exp_r.switch_on_request, switch_on_request);
				check_field("switch_off_request", exp_r.switch_off_request, switch_off_request);
				check_field("supply_timer_ctl", exp_r.supply_timer_ctl, supply_timer_ctl);
				check_field("recovery_timer_ctl", exp_r.recovery_timer_ctl, recovery_timer_ctl);
				check_field("reset_timer_ctl", exp_r.reset_timer_ctl, reset_timer_ctl);
				check_field("notify_pulse", exp_r.notify_pulse, notify_pulse);
				check_field("attempts_left", exp_r.attempts_left, attempts_left);
				check_field("modulator_action", exp_r.modulator_action, modulator_action);
			end
		end
		if (start_hold) begin
			rx_stall_left = LONG_HOLD;
		end else if (rx_stall_left > 0) begin
			rx_stall_left--;
		end else if (rx_idle_pct != 0 && $urandom_range(1, 100) <= rx_idle_pct) begin
			rx_stall_left = $urandom_range(1, 15);
		end
		res_ready <= (rx_stall_left == 0);
	end

	task test_directed_ac_path();
		send_event(4'd15, 1'b1, 1'b1, 2'd3);
		send_event(4'd9, 1'b0, 1'b0, 2'd0);
		send_event(EV_CLOSE, 1'b0, 1'b0, SC_OTHER);
		send_event(EV_ZERO_CROSS, 1'b0, 1'b0, SC_OTHER);
		send_event(EV_ZERO_CROSS, 1'b0, 1'b0, SC_OTHER);
		send_event(EV_SUPPLY_TMR, 1'b0, 1'b0, SC_OTHER);
		send_event(EV_SW_CLOSED, 1'b1, 1'b0, SC_OTHER);
		send_event(EV_ZERO_CROSS, 1'b1, 1'b0, SC_OTHER);
		send_event(EV_OCD, 1'b1, 1'b0, SC_OTHER);
		send_event(EV_ZERO_CROSS, 1'b1, 1'b0, SC_OTHER);
		send_event(EV_SW_OPENED, 1'b0, 1'b0, SC_OCP);
		send_event(EV_ZERO_CROSS, 1'b0, 1'b0, SC_OTHER);
	endtask

	task test_directed_dc_path();
		send_event(EV_CLOSE, 1'b0, 1'b0, SC_OTHER);
		send_event(EV_SUPPLY_TMR, 1'b0, 1'b1, SC_OCP);
		send_event(EV_ZERO_CROSS, 1'b0, 1'b1, SC_OTHER);
		send_event(EV_RECOVERY_TMR, 1'b0, 1'b1, 2'd3);
		send_event(EV_RECOVERY_TMR, 1'b0, 1'b1, SC_EXT);
		send_event(EV_SW_CLOSED, 1'b1, 1'b0, SC_OTHER);
		send_event(EV_SW_OPENED, 1'b1, 1'b0, SC_EXT);
		send_event(EV_SW_OPENED, 1'b0, 1'b0, SC_OTHER);
	endtask

	task test_directed_recovery();
		set_config(REG_RECOVERY, 32'd1);
		set_config(REG_MODE, 32'd1);
		send_event(EV_CLOSE, 1'b0, 1'b0, SC_OTHER);
		send_event(EV_SUPPLY_TMR, 1'b0, 1'b0, SC_OTHER);
		send_event(EV_SW_CLOSED, 1'b1, 1'b0, SC_OTHER);
		send_event(EV_SW_OPENED, 1'b1, 1'b0, SC_OCP);
		send_event(EV_SW_CLOSED, 1'b1, 1'b0, SC_OTHER);
		send_event(EV_RESET_TMR, 1'b1, 1'b0, SC_OTHER);
		send_event(EV_OPEN, 1'b1, 1'b0, SC_OTHER);
		send_event(EV_SW_OPENED, 1'b0, 1'b0, SC_OTHER);
	endtask

	// The receiver stops for a long stretch while events keep coming.
	task test_result_backpressure();
		int k;
		logic [3:0] ev;
		logic sw_on, fails;
		logic [1:0] sc;
		tx_idle_pct = 0;
		cmd_valid <= 1'b0;
		start_hold <= 1'b1;
		@(posedge clk);
		start_hold <= 1'b0;
		for (k = 0; k < 40; k++) begin
			pick_event(ev, sw_on, fails, sc);
			send_event(ev, sw_on, fails, sc);
		end
	endtask

	task test_crossing_saturation();
		int k;
		tx_idle_pct = 10;
		set_config(REG_AC_MIN, 32'd255);
		while (mdl_state != ST_OPENED) begin
			send_event((mdl_state == ST_OPEN_WAIT) ? EV_SW_OPENED : EV_OPEN, 1'b0, 1'b0,
				SC_OTHER);
		end
		send_event(EV_CLOSE, 1'b0, 1'b0, SC_OTHER);
		for (k = 0; k < 300; k++) begin
			send_event(EV_ZERO_CROSS, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				2'($urandom_range(0, 3)));
		end
		// A saturated count still meets the largest threshold.
		send_event(EV_SUPPLY_TMR, 1'b0, 1'b0, SC_OTHER);
		send_event(EV_OPEN, 1'b0, 1'b0, SC_OTHER);
		// A zero threshold judges the supply AC even with no crossing at all.
		set_config(REG_AC_MIN, 32'd0);
		send_event(EV_CLOSE, 1'b0, 1'b0, SC_OTHER);
		send_event(EV_SUPPLY_TMR, 1'b0, 1'b1, SC_OCP);
		send_event(EV_OPEN, 1'b0, 1'b0, SC_OTHER);
	endtask

	task test_random_phases(int phases, int per_phase);
		int p, k;
		logic [3:0] ev;
		logic sw_on, fails;
		logic [1:0] sc;
		logic [31:0] noise;
		logic [31:0] val;
		for (p = 0; p < phases; p++) begin
			noise = $urandom() & 32'hFFFF_FF00;
			case ($urandom_range(0, 3))
				0: val = 32'd0;
				1: val = 32'd255;
				2: val = 32'd1;
				default: val = $urandom_range(2, 6);
			endcase
			set_config(REG_RECOVERY, val | noise);
			set_config(REG_MODE, ($urandom() & 32'hFFFF_FFFE) | $urandom_range(0, 1));
			case ($urandom_range(0, 5))
				0: val = 32'd1;
				1: val = 32'd255;
				2: val = 32'd2;
				default: val = $urandom_range(1, 5);
			endcase
			set_config(REG_AC_MIN, val | noise);
			// The last two phases run with both sides always ready.
			if (p >= phases - 2) begin
				tx_idle_pct = 0;
				rx_idle_pct <= 0;
			end else if ($urandom_range(0, 3) == 0) begin
				tx_idle_pct = 0;
				rx_idle_pct <= 0;
			end else begin
				tx_idle_pct = $urandom_range(5, 40);
				rx_idle_pct <= $urandom_range(2, 20);
			end
			for (k = 0; k < per_phase; k++) begin
				pick_event(ev, sw_on, fails, sc);
				send_event(ev, sw_on, fails, sc);
			end
		end
	endtask

	initial begin
		cfg.recovery_attempts = 8'd0;
		cfg.close_mode = 1'b0;
		cfg.ac_crossing_min = AC_MIN_RESET;
		mdl_state = ST_OPENED;
		mdl_cause = CA_NONE;
		mdl_count = '0;
		mdl_ac = 1'b0;
		mdl_masked = 1'b0;
		mdl_attempts = '0;
		mdl_mode = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		tx_idle_pct = 20;
		rx_idle_pct <= 15;
		test_directed_ac_path();
		test_directed_dc_path();
		test_directed_recovery();
		test_result_backpressure();
		test_crossing_saturation();
		rx_idle_pct <= 15;
		test_random_phases(12, 50);
		cmd_valid <= 1'b0;
		while (pending_breaker_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		$display("Sent %0d event beats and checked %0d result beats across %0d register writes,",
			events_sent, results_seen, config_writes);
		$display("covering all states, trip causes, recovery, mode changes and a long stall.");
		if (error_count == 0 && pending_breaker_results.size() == 0) begin
			$display("tb_breaker_main_state_machine passed");
		end else begin
			$display("tb_breaker_main_state_machine failed");
		end
		$finish;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Run stopped at the cycle limit with %0d results outstanding.",
			pending_breaker_results.size());
		$display("tb_breaker_main_state_machine failed");
		$finish;
	end

endmodule

[files.f]
+incdir+sv
sv/bms_pkg.sv
sv/bms_regs.sv
sv/bms_fsm.sv
sv/bms_out.sv
sv/breaker_main_state_machine.sv
dv/tb_breaker_main_state_machine.sv
